// File: rtl/e2e_crc8_counter_checker_assert.svh
// assertion macros shared by the checker rtl
// depends on nothing; included by the modules that carry assertions
`ifndef E2E_CRC8_COUNTER_CHECKER_ASSERT_SVH
`define E2E_CRC8_COUNTER_CHECKER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define E2E_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("e2e checker assertion failed");

// next-cycle implication, checked out of reset
`define E2E_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("e2e checker assertion failed");

`endif

// File: rtl/e2ecrc_pkg.sv
// shared types, status codes and the crc-8 byte update for the e2e checker
// depends on nothing
`timescale 1ns / 1ps

package e2ecrc_pkg;

  localparam logic [7:0] CrcPoly    = 8'h1D;
  localparam logic [7:0] CrcInit    = 8'hFF;
  localparam logic [3:0] CntMaxInit = 4'd14;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_REPEATED    = 3'd1,
    ST_WRONG_SEQ   = 3'd2,
    ST_WRONG_CRC   = 3'd3,
    ST_NO_NEW_DATA = 3'd4
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } item_t;

  // byte position codes
  localparam logic [1:0] PosCrc  = 2'd0;
  localparam logic [1:0] PosCnt  = 2'd1;
  localparam logic [1:0] PosSat  = 2'd3;

  // msb-first crc-8 update of one byte
  function automatic logic [7:0] crc_fold(logic [7:0] crc, logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: rtl/e2ecrc_in_stage.sv
// input register stage: holds one accepted item until the core consumes it
// depends on e2ecrc_pkg
`timescale 1ns / 1ps

module e2ecrc_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  e2ecrc_pkg::item_t   item_i,
  input  logic                advance_i,
  output logic                valid_o,
  output e2ecrc_pkg::item_t   item_o
);

  logic              valid_q;
  e2ecrc_pkg::item_t item_q;

  // take a new item when empty or when the held one moves on
  assign in_ready_o = !valid_q || advance_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// File: rtl/e2ecrc_core.sv
// message state, crc accumulation and counter classification
// depends on e2ecrc_pkg and e2e_crc8_counter_checker_assert.svh
`timescale 1ns / 1ps
`include "e2e_crc8_counter_checker_assert.svh"

module e2ecrc_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  go_i,
  input  e2ecrc_pkg::item_t     item_i,
  input  logic [3:0]            counter_max_i,
  output e2ecrc_pkg::status_e   status_o
);

  logic [7:0] crc_q, crc_d;
  logic [1:0] pos_q, pos_d;
  logic [7:0] rx_crc_q, rx_crc_d;
  logic [3:0] rx_cnt_q, rx_cnt_d;
  logic [3:0] last_cnt_q, last_cnt_d;
  logic [7:0] crc_next;
  logic       crc_match;
  logic       short_msg;

  assign crc_next  = e2ecrc_pkg::crc_fold(crc_q, item_i.data_byte);
  assign crc_match = (~crc_next) == rx_crc_q;
  assign short_msg = (pos_q == e2ecrc_pkg::PosCrc) || (pos_q == e2ecrc_pkg::PosCnt);

  // status of the final byte
  always_comb begin
    if (short_msg) begin
      status_o = e2ecrc_pkg::ST_NO_NEW_DATA;
    end else if (!crc_match) begin
      status_o = e2ecrc_pkg::ST_WRONG_CRC;
    end else if (rx_cnt_q == last_cnt_q) begin
      status_o = e2ecrc_pkg::ST_REPEATED;
    end else if ((last_cnt_q < counter_max_i) && (rx_cnt_q < last_cnt_q)) begin
      status_o = e2ecrc_pkg::ST_WRONG_SEQ;
    end else begin
      status_o = e2ecrc_pkg::ST_OK;
    end
  end

  // next state for one byte
  always_comb begin
    crc_d      = crc_q;
    pos_d      = pos_q;
    rx_crc_d   = rx_crc_q;
    rx_cnt_d   = rx_cnt_q;
    last_cnt_d = last_cnt_q;
    if (pos_q == e2ecrc_pkg::PosCrc) begin
      rx_crc_d = item_i.data_byte;
    end else begin
      crc_d = crc_next;
      if (pos_q == e2ecrc_pkg::PosCnt) begin
        rx_cnt_d = item_i.data_byte[3:0];
      end
    end
    if (pos_q != e2ecrc_pkg::PosSat) begin
      pos_d = pos_q + 2'd1;
    end
    // final byte: keep counter if accepted, rearm for next message
    if (item_i.last) begin
      if (!short_msg && crc_match) begin
        last_cnt_d = rx_cnt_q;
      end
      crc_d = e2ecrc_pkg::CrcInit;
      pos_d = e2ecrc_pkg::PosCrc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q      <= e2ecrc_pkg::CrcInit;
      pos_q      <= e2ecrc_pkg::PosCrc;
      rx_crc_q   <= '0;
      rx_cnt_q   <= '0;
      last_cnt_q <= '0;
    end else if (go_i) begin
      crc_q      <= crc_d;
      pos_q      <= pos_d;
      rx_crc_q   <= rx_crc_d;
      rx_cnt_q   <= rx_cnt_d;
      last_cnt_q <= last_cnt_d;
    end
  end

  // rearm after every final byte
  `E2E_ASSERT_NEXT(a_rearm, clk_i, rst_ni, go_i && item_i.last,
                   (pos_q == e2ecrc_pkg::PosCrc) && (crc_q == e2ecrc_pkg::CrcInit))
  // stored counter moves only on a consumed final byte
  `E2E_ASSERT_NEXT(a_cnt_hold, clk_i, rst_ni, !(go_i && item_i.last), $stable(last_cnt_q))
  // a final byte in the first two positions reports no new data
  `E2E_ASSERT_NOW(a_short, clk_i, rst_ni, go_i && item_i.last && short_msg,
                  status_o == e2ecrc_pkg::ST_NO_NEW_DATA)

endmodule

// File: rtl/e2ecrc_out_stage.sv
// result register: holds one status item until the consumer takes it
// depends on e2ecrc_pkg
`timescale 1ns / 1ps

module e2ecrc_out_stage (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  e2ecrc_pkg::status_e   status_i,
  output logic                  free_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [2:0]            status_o
);

  logic                valid_q;
  e2ecrc_pkg::status_e status_q;

  // slot can take a result when empty or being drained this cycle
  assign free_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && free_o) begin
      status_q <= status_i;
    end
  end

  assign out_valid_o = valid_q;
  assign status_o    = 3'(status_q);

endmodule

// File: rtl/e2e_crc8_counter_checker.sv
// top level of the e2e crc-8 and counter checker
// depends on e2ecrc_pkg, e2ecrc_in_stage, e2ecrc_core, e2ecrc_out_stage and the assert header
//
//   channel   handshake                 payload
//   input     in_valid_i / in_ready_o   data_byte_i[7:0], last_i
//   result    out_valid_o / out_ready_i status_o[2:0]
//   config    cfg_valid_i / cfg_ready_o cfg_data_i[3:0] (counter_max)
//
// one byte per cycle sustained; an item waits in the input register,
// and the crc update and status decision sit between that register and the result register.
// a final byte's status enters the result register at the edge where the byte leaves the
// input register, so if the slot is free, out_valid_o rises at that same edge.
// rst_ni clears all control state and sets counter_max to 14; no clearing pass.
// only a final byte waits on a full result register; other bytes never stall.
`timescale 1ns / 1ps
`include "e2e_crc8_counter_checker_assert.svh"

module e2e_crc8_counter_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] status_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [3:0] cfg_data_i
);

  e2ecrc_pkg::item_t   in_item;
  e2ecrc_pkg::item_t   s1_item;
  e2ecrc_pkg::status_e core_status;
  logic                s1_valid;
  logic                advance;
  logic                out_free;
  logic                load_result;
  logic [3:0]          cnt_max_q;

  assign in_item.data_byte = data_byte_i;
  assign in_item.last      = last_i;

  // configuration register, always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_max_q <= e2ecrc_pkg::CntMaxInit;
    end else if (cfg_valid_i && cfg_ready_o) begin
      cnt_max_q <= cfg_data_i;
    end
  end

  // held item moves on unless it is a final byte facing a full result slot
  assign advance     = s1_valid && (!s1_item.last || out_free);
  assign load_result = advance && s1_item.last;

  e2ecrc_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (in_item),
    .advance_i  (advance),
    .valid_o    (s1_valid),
    .item_o     (s1_item)
  );

  e2ecrc_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .go_i          (advance),
    .item_i        (s1_item),
    .counter_max_i (cnt_max_q),
    .status_o      (core_status)
  );

  e2ecrc_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load_result),
    .status_i    (core_status),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o)
  );

  // a consumed final byte always lands in the result register
  `E2E_ASSERT_NEXT(a_result_loaded, clk_i, rst_ni, load_result, out_valid_o)
  // non-final bytes never stall the input side
  `E2E_ASSERT_NOW(a_no_stall, clk_i, rst_ni, s1_valid && !s1_item.last, in_ready_o)
  // a stalled final byte means the result slot is occupied
  `E2E_ASSERT_NOW(a_stall_cause, clk_i, rst_ni, s1_valid && !advance,
                  out_valid_o && !out_ready_i)

endmodule

// File: verif/e2e_crc8_counter_checker_tb.sv
// self-checking testbench for the e2e crc-8 and counter checker
// depends on e2ecrc_pkg and the e2e_crc8_counter_checker rtl; drives random and directed messages
`timescale 1ns / 1ps

module e2e_crc8_counter_checker_tb;

  localparam int SettleCycles = 8;
  localparam int WatchdogLimit = 2000;
  localparam int HoldLen = 300;
  localparam int PhaseBytes = 100;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [7:0] data_byte_i = 8'h00;
  logic       last_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [2:0] status_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [3:0] cfg_data_i = 4'h0;

  // stimulus and scoreboard storage
  e2ecrc_pkg::item_t   msg_byte_q[$];
  e2ecrc_pkg::status_e status_due_q[$];
  int      src_idle_pct = 0;
  int      sink_stall_pct = 0;
  logic    squeeze_on = 1'b0;
  int      hold_cnt = 0;
  logic    byte_taken = 1'b0;
  int      n_err = 0;
  int      quiet_cycles = 0;
  logic [3:0] gen_cnt = 4'h0;

  // checker state mirrored in the testbench
  logic [7:0] chk_crc = e2ecrc_pkg::CrcInit;
  logic [1:0] chk_pos = e2ecrc_pkg::PosCrc;
  logic [7:0] chk_rx_crc = 8'h00;
  logic [3:0] chk_rx_cnt = 4'h0;
  logic [3:0] chk_last_cnt = 4'h0;
  logic [3:0] chk_cnt_max = e2ecrc_pkg::CntMaxInit;

  e2e_crc8_counter_checker u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .last_i      (last_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // crc-8 over one byte, polynomial 0x1d, msb first
  function automatic logic [7:0] crc8_step(logic [7:0] crc, logic [7:0] b);
    logic [7:0] r;
    int k;
    r = crc ^ b;
    for (k = 0; k < 8; k++) begin
      r = {r[6:0], 1'b0} ^ (r[7] ? e2ecrc_pkg::CrcPoly : 8'h00);
    end
    return r;
  endfunction

  // fold one accepted byte into the mirrored state; returns 1 when a status is due
  function automatic bit absorb_byte(input logic [7:0] b, input logic fin,
                                     output e2ecrc_pkg::status_e st);
    logic [1:0] pos;
    pos = chk_pos;
    st = e2ecrc_pkg::ST_OK;
    if (pos == e2ecrc_pkg::PosCrc) begin
      chk_rx_crc = b;
    end else begin
      if (pos == e2ecrc_pkg::PosCnt) begin
        chk_rx_cnt = b[3:0];
      end
      chk_crc = crc8_step(chk_crc, b);
    end
    if (pos != e2ecrc_pkg::PosSat) begin
      chk_pos = pos + 2'd1;
    end
    if (!fin) begin
      return 1'b0;
    end
    if (pos == e2ecrc_pkg::PosCrc || pos == e2ecrc_pkg::PosCnt) begin
      st = e2ecrc_pkg::ST_NO_NEW_DATA;
    end else if (~chk_crc != chk_rx_crc) begin
      st = e2ecrc_pkg::ST_WRONG_CRC;
    end else begin
      if (chk_rx_cnt == chk_last_cnt) begin
        st = e2ecrc_pkg::ST_REPEATED;
      end else if (chk_last_cnt < chk_cnt_max && chk_rx_cnt < chk_last_cnt) begin
        st = e2ecrc_pkg::ST_WRONG_SEQ;
      end else begin
        st = e2ecrc_pkg::ST_OK;
      end
      chk_last_cnt = chk_rx_cnt;
    end
    chk_crc = e2ecrc_pkg::CrcInit;
    chk_pos = e2ecrc_pkg::PosCrc;
    return 1'b1;
  endfunction

  // queue one raw byte
  function automatic int push_raw(logic [7:0] b, logic fin);
    e2ecrc_pkg::item_t it;
    it.data_byte = b;
    it.last = fin;
    msg_byte_q.push_back(it);
    return 1;
  endfunction

  // queue a message: crc byte, counter byte, payload; fill < 0 means random payload
  function automatic int push_msg(logic [7:0] cnt_byte, int n_pay, bit crc_ok, int fill);
    logic [7:0] body[$];
    logic [7:0] crc;
    logic [7:0] rx;
    int i;
    int n;
    body.push_back(cnt_byte);
    for (i = 0; i < n_pay; i++) begin
      body.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
    end
    crc = e2ecrc_pkg::CrcInit;
    foreach (body[j]) begin
      crc = crc8_step(crc, body[j]);
    end
    rx = ~crc;
    if (!crc_ok) begin
      rx ^= 8'h01 << $urandom_range(7);
    end
    n = push_raw(rx, 1'b0);
    foreach (body[j]) begin
      n += push_raw(body[j], j == body.size() - 1);
    end
    return n;
  endfunction

  // random message, mostly well formed with a plausible counter step
  function automatic int push_random_msg();
    int sel;
    int n_pay;
    int n;
    sel = $urandom_range(99);
    if (sel < 8) begin
      // too short to carry data
      if ($urandom_range(1) == 0) begin
        n = push_raw(8'($urandom), 1'b1);
      end else begin
        n = push_raw(8'($urandom), 1'b0);
        n += push_raw(8'($urandom), 1'b1);
      end
      return n;
    end
    n_pay = ($urandom_range(9) != 0) ? $urandom_range(1, 4) : $urandom_range(5, 20);
    sel = $urandom_range(9);
    if (sel < 5) begin
      gen_cnt = gen_cnt + 4'd1;
    end else if (sel == 6) begin
      gen_cnt = gen_cnt + 4'($urandom_range(2, 3));
    end else if (sel == 7) begin
      gen_cnt = gen_cnt - 4'($urandom_range(1, 3));
    end else if (sel >= 8) begin
      gen_cnt = 4'($urandom);
    end
    return push_msg({4'($urandom), gen_cnt}, n_pay, $urandom_range(99) >= 10, -1);
  endfunction

  // input driver: presents queued bytes, holds each until it is taken
  always @(negedge clk_i) begin : drv
    e2ecrc_pkg::item_t cur;
    if (rst_ni && (!in_valid_i || byte_taken)) begin
      if (msg_byte_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        cur = msg_byte_q.pop_front();
        in_valid_i <= 1'b1;
        data_byte_i <= cur.data_byte;
        last_i <= cur.last;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result side ready, with a long hold-off while squeezing
  always @(negedge clk_i) begin
    if (squeeze_on && hold_cnt < HoldLen) begin
      hold_cnt <= hold_cnt + 1;
      out_ready_i <= 1'b0;
    end else begin
      if (!squeeze_on) begin
        hold_cnt <= 0;
      end
      out_ready_i <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // monitor: predict on accepted bytes, compare on accepted results
  always @(posedge clk_i) begin : mon
    e2ecrc_pkg::status_e exp_st;
    if (!rst_ni) begin
      byte_taken = 1'b0;
    end else begin
      byte_taken = in_valid_i && in_ready_o;
      if (cfg_valid_i && cfg_ready_o) begin
        chk_cnt_max = cfg_data_i;
      end
      if (byte_taken && absorb_byte(data_byte_i, last_i, exp_st)) begin
        status_due_q.push_back(exp_st);
      end
      if (out_valid_o && out_ready_i) begin
        if (status_due_q.size() == 0) begin
          $error("status: unexpected result, actual %0d", status_o);
          n_err++;
        end else begin
          exp_st = status_due_q.pop_front();
          if (status_o !== exp_st) begin
            $error("status mismatch: expected %0d (%s), actual %0d",
                   exp_st, exp_st.name(), status_o);
            n_err++;
          end
        end
      end
    end
  end

  // watchdog on cycles without any accepted item
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // wait until every byte is taken and every status has come back
  task automatic wait_drained();
    do begin
      @(posedge clk_i);
    end while (msg_byte_q.size() != 0 || in_valid_i || status_due_q.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // write counter_max while the block is idle
  task automatic write_cnt_max(logic [3:0] v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do begin
      @(posedge clk_i);
    end while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // one random phase under a given setting and idling pattern
  task automatic run_phase(logic [3:0] cmax, int src_pct, int sink_pct, bit squeeze);
    int n;
    wait_drained();
    write_cnt_max(cmax);
    src_idle_pct = src_pct;
    sink_stall_pct = sink_pct;
    squeeze_on = squeeze;
    n = 0;
    while (n < PhaseBytes) begin
      n += push_random_msg();
    end
    wait_drained();
    squeeze_on = 1'b0;
  endtask

  initial begin : seq
    int n;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed messages at the reset value of counter_max
    n = push_raw(8'hFF, 1'b1);
    n += push_raw(8'h00, 1'b0);
    n += push_raw(8'hFF, 1'b1);
    n += push_msg(8'hF0, 1, 1'b1, 8'hFF);  // repeated counter
    n += push_msg(8'h01, 1, 1'b1, 8'h00);  // ok
    n += push_msg(8'h05, 1, 1'b0, 8'h5A);  // crc mismatch
    n += push_msg(8'h00, 1, 1'b1, 8'hA5);  // counter went backwards
    n += push_msg(8'h0F, 4, 1'b1, -1);     // long message, counter at top
    n += push_msg(8'h32, 1, 1'b1, -1);     // wrap from the top
    wait_drained();

    // random phases over several counter_max settings
    run_phase(4'd0, 0, 0, 1'b0);
    run_phase(4'd15, 85, 0, 1'b0);
    run_phase(4'd7, 0, 85, 1'b0);
    run_phase(4'd1, 35, 35, 1'b0);
    run_phase(4'd14, 0, 0, 1'b1);

    wait_drained();
    if (n_err == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
